FILE: hdl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants for the per-source rate limiter: table geometry,
// slot entry layout, address kinds, result outcomes and register map.
// ----------------------------------------------------------------------------
package psrl_pkg;

   // Table geometry; the slot count must be a power of two (slot = hash mask)
   localparam int unsigned TABLE_SLOTS = 512;
   localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);

   // Key sizes
   localparam int unsigned MAX_KEY_BYTES = 16;
   localparam int unsigned KEY_LEN_W     = $clog2(MAX_KEY_BYTES + 1);

   // djb2 seed
   localparam logic [31:0] HASH_SEED = 32'd5381;

   // Register reset values
   localparam logic [15:0] HIT_LIMIT_RESET = 16'd100;
   localparam logic [7:0]  WINDOW_RESET    = 8'd1;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_FIELDS_W = 1 + SLOT_W + 3;
   localparam int unsigned RSP_DATA_W   = 8 * ((RSP_FIELDS_W + 7) / 8);

   // Address kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_IPV4  = 2'd1;
   localparam logic [1:0] KIND_IPV6  = 2'd2;

   // Result outcomes
   localparam logic [2:0] OUT_RESTART   = 3'd0;
   localparam logic [2:0] OUT_COUNTED   = 3'd1;
   localparam logic [2:0] OUT_DROPPED   = 3'd2;
   localparam logic [2:0] OUT_CLAIMED   = 3'd3;
   localparam logic [2:0] OUT_COLLISION = 3'd4;

   // Register map (word index)
   localparam logic REG_HIT_LIMIT = 1'b0;
   localparam logic REG_WINDOW    = 1'b1;

   // One table slot
   typedef struct packed {
      logic [63:0]          key_upper;
      logic [63:0]          key_lower;
      logic [KEY_LEN_W-1:0] key_length;
      logic [31:0]          window_begin;
      logic [15:0]          hits;
   } slot_entry_type;

   // Write port of the slot table
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      slot_entry_type    data;
   } slot_write_type;

endpackage

FILE: hdl/psrl_hash_unit.sv
// ----------------------------------------------------------------------------
// psrl_hash_unit
// Iterative djb2 hash: one shared multiply-by-33-and-add step per cycle,
// one key byte per step, most significant byte first.
// ----------------------------------------------------------------------------
module psrl_hash_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [63:0]                    key_upper,
   input  logic [63:0]                    key_lower,
   input  logic [psrl_pkg::KEY_LEN_W-1:0] key_length,
   output logic                           busy,
   output logic [31:0]                    hash
);

   logic [31:0]                    hash_ff, hash_in;
   logic [127:0]                   bytes_ff, bytes_in;
   logic [psrl_pkg::KEY_LEN_W-1:0] count_ff, count_in;
   logic [31:0]                    step_sum;

   // Shared step: h * 33 + byte
   assign step_sum = {hash_ff[26:0], 5'b0} + hash_ff + {24'b0, bytes_ff[127:120]};

   always_comb begin
      hash_in  = hash_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (start) begin
         hash_in  = psrl_pkg::HASH_SEED;
         bytes_in = {key_upper, key_lower};
         count_in = key_length;
      end else if (count_ff != '0) begin
         hash_in  = step_sum;
         bytes_in = {bytes_ff[119:0], 8'b0};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      hash_ff  <= hash_in;
      bytes_ff <= bytes_in;
   end

   assign busy = (count_ff != '0);
   assign hash = hash_ff;

endmodule

FILE: hdl/psrl_slot_ram.sv
// ----------------------------------------------------------------------------
// psrl_slot_ram
// Slot table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psrl_slot_ram (
   input  logic                        clock,
   input  psrl_pkg::slot_write_type    wr,
   input  logic                        rd_en,
   input  logic [psrl_pkg::SLOT_W-1:0] rd_addr,
   output psrl_pkg::slot_entry_type    rd_data
);

   psrl_pkg::slot_entry_type mem [psrl_pkg::TABLE_SLOTS];
   psrl_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/per_source_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// per_source_rate_limiter_core
// Per-source fixed-window rate limiter: djb2 hash of the source address
// selects a direct-mapped slot that counts hits per window.
// ----------------------------------------------------------------------------
//
//   Port group | Direction | Word contents
//   -----------+-----------+--------------------------------------------------
//   req_*      | in        | source address, time; address kind on tuser
//   rsp_*      | out       | allowed, slot index, outcome
//   csr_*      | in/out    | hit_limit (0x0), window_seconds (0x4)
//
// A request runs through hashing, table read, check and commit before the
// next request is accepted; the shared hash step takes one key byte a
// cycle: sixteen bytes for IPv6, four for IPv4, none for another family.
// After reset a clearing pass zeroes all 512 slots, one per cycle; req_tready
// stays low meanwhile. One finished word waits in the output register while
// the next request is accepted and hashed; commit stalls if it is still full.
//
module per_source_rate_limiter_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] addr_upper, [127:64] addr_lower, [159:128] now_seconds
   input  logic [psrl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] addr_kind
   input  logic [psrl_pkg::REQ_USER_W-1:0]   req_tuser,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] allowed, [9:1] slot_index, [12:10] outcome, rest zero
   output logic [psrl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_HASH   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_CHECK  = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [15:0] hit_limit_ff, hit_limit_in;
   logic [7:0]  window_ff, window_in;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      hit_limit_in = hit_limit_ff;
      window_in    = window_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            psrl_pkg::REG_HIT_LIMIT: hit_limit_in = csr_pwdata[15:0];
            psrl_pkg::REG_WINDOW:    window_in    = csr_pwdata[7:0];
            default:                 hit_limit_in = hit_limit_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         psrl_pkg::REG_HIT_LIMIT: csr_prdata = {16'b0, hit_limit_ff};
         psrl_pkg::REG_WINDOW:    csr_prdata = {24'b0, window_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Request normalization: unused bytes cleared, length from kind
   logic [63:0]                    norm_upper;
   logic [63:0]                    norm_lower;
   logic [psrl_pkg::KEY_LEN_W-1:0] norm_length;

   always_comb begin
      case (req_tuser)
         psrl_pkg::KIND_IPV4: begin
            norm_upper  = {req_tdata[63:32], 32'b0};
            norm_lower  = '0;
            norm_length = psrl_pkg::KEY_LEN_W'(4);
         end
         psrl_pkg::KIND_IPV6: begin
            norm_upper  = req_tdata[63:0];
            norm_lower  = req_tdata[127:64];
            norm_length = psrl_pkg::KEY_LEN_W'(psrl_pkg::MAX_KEY_BYTES);
         end
         default: begin
            norm_upper  = '0;
            norm_lower  = '0;
            norm_length = '0;
         end
      endcase
   end

   logic req_accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // Captured request
   logic [63:0]                    key_upper_ff;
   logic [63:0]                    key_lower_ff;
   logic [psrl_pkg::KEY_LEN_W-1:0] key_length_ff;
   logic [31:0]                    now_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         key_upper_ff  <= norm_upper;
         key_lower_ff  <= norm_lower;
         key_length_ff <= norm_length;
         now_ff        <= req_tdata[159:128];
      end
   end

   // Hash unit
   logic        hash_busy;
   logic [31:0] hash;

   psrl_hash_unit u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .key_upper  (norm_upper),
      .key_lower  (norm_lower),
      .key_length (norm_length),
      .busy       (hash_busy),
      .hash       (hash)
   );

   logic [psrl_pkg::SLOT_W-1:0] slot;
   assign slot = hash[psrl_pkg::SLOT_W-1:0];

   // Slot table
   psrl_pkg::slot_write_type wr;
   psrl_pkg::slot_entry_type entry;
   logic                     rd_en;

   assign rd_en = (state_ff == ST_READ);

   psrl_slot_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (entry)
   );

   // Check stage: key match, window test, saturating count
   logic        match_ff, match_in;
   logic        empty_ff, empty_in;
   logic        in_win_ff, in_win_in;
   logic [15:0] hits_inc_ff, hits_inc_in;
   logic [31:0] age;

   always_comb begin
      age         = now_ff - entry.window_begin;
      match_in    = (entry.key_length == key_length_ff) &&
                    (entry.key_upper == key_upper_ff) &&
                    (entry.key_lower == key_lower_ff);
      empty_in    = (entry.key_length == '0);
      in_win_in   = (age < {24'b0, window_ff});
      hits_inc_in = (entry.hits == 16'hFFFF) ? entry.hits : entry.hits + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         match_ff    <= match_in;
         empty_ff    <= empty_in;
         in_win_ff   <= in_win_in;
         hits_inc_ff <= hits_inc_in;
      end
   end

   // Clearing pass address
   logic [psrl_pkg::SLOT_W-1:0] clear_addr_ff, clear_addr_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [psrl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          commit;
   logic                          allowed;
   logic [2:0]                    outcome;
   psrl_pkg::slot_entry_type      new_entry;

   assign commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);

   // Commit decision and table update
   always_comb begin
      allowed                = 1'b1;
      outcome                = psrl_pkg::OUT_COLLISION;
      new_entry.key_upper    = key_upper_ff;
      new_entry.key_lower    = key_lower_ff;
      new_entry.key_length   = key_length_ff;
      new_entry.window_begin = now_ff;
      new_entry.hits         = 16'd1;
      wr.en                  = 1'b0;
      wr.addr                = slot;
      wr.data                = new_entry;
      if (match_ff) begin
         if (in_win_ff) begin
            new_entry.window_begin = entry.window_begin;
            new_entry.hits         = hits_inc_ff;
            if (hits_inc_ff > hit_limit_ff) begin
               allowed = 1'b0;
               outcome = psrl_pkg::OUT_DROPPED;
            end else begin
               outcome = psrl_pkg::OUT_COUNTED;
            end
         end else begin
            outcome = psrl_pkg::OUT_RESTART;
         end
         wr.en = commit;
      end else if (empty_ff) begin
         outcome = psrl_pkg::OUT_CLAIMED;
         wr.en   = commit;
      end
      wr.data = new_entry;
      // Clearing pass overrides the port
      if (state_ff == ST_CLEAR) begin
         wr.en   = 1'b1;
         wr.addr = clear_addr_ff;
         wr.data = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = psrl_pkg::RSP_DATA_W'({outcome, slot, allowed});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (!hash_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         hit_limit_ff  <= psrl_pkg::HIT_LIMIT_RESET;
         window_ff     <= psrl_pkg::WINDOW_RESET;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_limit_ff  <= hit_limit_in;
         window_ff     <= window_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_HASH))
      else $error("accepted request did not enter hashing");

   a_write_only_clear_or_commit: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> ((state_ff == ST_CLEAR) || (state_ff == ST_COMMIT)))
      else $error("slot table written outside clear or commit");

   a_commit_loads_output: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_tvalid && (state_ff == ST_IDLE)))
      else $error("commit did not present a result");

   a_drop_matches_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[psrl_pkg::SLOT_W+3:psrl_pkg::SLOT_W+1] ==
                       psrl_pkg::OUT_DROPPED) == !rsp_tdata[0]))
      else $error("allowed flag disagrees with outcome");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_tready && !rsp_tvalid))
      else $error("traffic during clearing pass");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-source rate limiter core. A table of
// directed requests and register writes runs first, then three random
// phases built around a small pool of repeating sources. Every response word
// is compared with a software copy of the slot table; typed steps fix the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_CYCLES      = 400;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int MAX_REPORTS      = 100;
   localparam int PHASE_ITEMS      = 550;
   localparam int POOL_SIZE        = 24;

   // Kind code with no name in the package; behaves like another family
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   // Directed address used for the window and limit checks
   localparam logic [63:0] HOST_UPPER     = 64'hC0A80001_DEADBEEF;
   localparam logic [63:0] HOST_LOWER     = 64'h01234567_89ABCDEF;
   localparam logic [63:0] HOST_UPPER_ALT = 64'hC0A80001_12345678;

   typedef struct {
      logic [63:0] upper;
      logic [63:0] lower;
      logic [1:0]  kind;
      logic [31:0] now;
   } request_type;

   typedef struct {
      logic                        allowed;
      logic [psrl_pkg::SLOT_W-1:0] slot;
      logic [2:0]                  outcome;
   } verdict_type;

   typedef enum logic [1:0] {STEP_REQUEST, STEP_LIMIT, STEP_WINDOW} step_op_type;

   typedef struct {
      step_op_type op;
      request_type rq;
      logic [31:0] value;
      bit          typed;
      logic        allowed;
      logic [2:0]  outcome;
   } step_type;

   // DUT connections
   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [psrl_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic [psrl_pkg::REQ_USER_W-1:0] req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [psrl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [2:0]                      csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   // Shadow slot table and registers
   logic [63:0]                    shadow_upper  [psrl_pkg::TABLE_SLOTS];
   logic [63:0]                    shadow_lower  [psrl_pkg::TABLE_SLOTS];
   logic [psrl_pkg::KEY_LEN_W-1:0] shadow_length [psrl_pkg::TABLE_SLOTS];
   logic [31:0]                    shadow_start  [psrl_pkg::TABLE_SLOTS];
   logic [15:0]                    shadow_hits   [psrl_pkg::TABLE_SLOTS];
   logic [15:0]                    limit_cfg;
   logic [7:0]                     window_cfg;

   verdict_type pending_verdicts[$];
   step_type    directed_steps[$];
   request_type source_pool[POOL_SIZE];
   logic [31:0] wall_clock;
   int          error_count     = 0;
   int          csr_error_count = 0;
   int          send_idle_pct   = 0;
   int          recv_idle_pct   = 0;
   int          hold_asks       = 0;
   int          hold_seen       = 0;
   int          hold_left       = 0;
   int          quiet_cycles    = 0;

   per_source_rate_limiter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // djb2 over the top nbytes of a word, most significant byte first
   function automatic logic [31:0] djb2_fold(input logic [31:0] h, input logic [63:0] w,
                                             input int nbytes);
      for (int i = 0; i < nbytes; i++) h = h * 33 + w[63 - 8 * i -: 8];
      return h;
   endfunction

   // Decide one request against the shadow table and update it
   function automatic verdict_type judge_request(input request_type rq);
      logic [63:0]                    up;
      logic [63:0]                    lo;
      logic [psrl_pkg::KEY_LEN_W-1:0] len;
      logic [31:0]                    h;
      logic [31:0]                    diff;
      logic [psrl_pkg::SLOT_W-1:0]    s;
      verdict_type                    v;
      up = rq.upper;
      lo = rq.lower;
      h = psrl_pkg::HASH_SEED;
      v.allowed = 1'b1;
      case (rq.kind)
         psrl_pkg::KIND_IPV4: begin
            len = psrl_pkg::KEY_LEN_W'(4);
            up = {up[63:32], 32'h0};
            lo = '0;
            h = djb2_fold(h, up, 4);
         end
         psrl_pkg::KIND_IPV6: begin
            len = psrl_pkg::KEY_LEN_W'(16);
            h = djb2_fold(h, up, 8);
            h = djb2_fold(h, lo, 8);
         end
         default: begin
            len = '0;
            up = '0;
            lo = '0;
         end
      endcase
      s = h[psrl_pkg::SLOT_W-1:0];
      v.slot = s;
      if (shadow_length[s] == len && shadow_upper[s] == up && shadow_lower[s] == lo) begin
         // same source: count within the window, else restart it
         diff = rq.now - shadow_start[s];
         if (diff < {24'h0, window_cfg}) begin
            if (shadow_hits[s] != 16'hFFFF) shadow_hits[s] = shadow_hits[s] + 16'd1;
            if (shadow_hits[s] > limit_cfg) begin
               v.allowed = 1'b0;
               v.outcome = psrl_pkg::OUT_DROPPED;
            end else begin
               v.outcome = psrl_pkg::OUT_COUNTED;
            end
         end else begin
            shadow_start[s] = rq.now;
            shadow_hits[s] = 16'd1;
            v.outcome = psrl_pkg::OUT_RESTART;
         end
      end else if (shadow_length[s] == '0) begin
         shadow_upper[s] = up;
         shadow_lower[s] = lo;
         shadow_length[s] = len;
         shadow_hits[s] = 16'd1;
         shadow_start[s] = rq.now;
         v.outcome = psrl_pkg::OUT_CLAIMED;
      end else begin
         v.outcome = psrl_pkg::OUT_COLLISION;
      end
      return v;
   endfunction

   function automatic void req_step(input logic [1:0] kind, input logic [63:0] up,
                                    input logic [63:0] lo, input logic [31:0] now,
                                    input bit typed, input logic allowed,
                                    input logic [2:0] outcome);
      step_type st;
      st.op = STEP_REQUEST;
      st.rq.kind = kind;
      st.rq.upper = up;
      st.rq.lower = lo;
      st.rq.now = now;
      st.value = '0;
      st.typed = typed;
      st.allowed = allowed;
      st.outcome = outcome;
      directed_steps.push_back(st);
   endfunction

   function automatic void csr_step(input step_op_type op, input logic [31:0] value);
      step_type st;
      st.op = op;
      st.rq.kind = psrl_pkg::KIND_OTHER;
      st.rq.upper = '0;
      st.rq.lower = '0;
      st.rq.now = '0;
      st.value = value;
      st.typed = PREDICTED;
      st.allowed = 1'b0;
      st.outcome = psrl_pkg::OUT_RESTART;
      directed_steps.push_back(st);
   endfunction

   // Offer one request word, hold it until taken, then log its verdict
   task automatic send_request(input request_type rq, input bit typed, input logic allowed,
                               input logic [2:0] outcome);
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rq.now, rq.lower, rq.upper};
      req_tuser <= rq.kind;
      do @(posedge clock); while (!req_tready);
      v = judge_request(rq);
      if (typed) begin
         v.allowed = allowed;
         v.outcome = outcome;
      end
      pending_verdicts.push_back(v);
   endtask

   // Drain, write one register, then read it back
   task automatic set_register(input logic reg_index, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] mask;
      mask = (reg_index == psrl_pkg::REG_HIT_LIMIT) ? 32'h0000FFFF : 32'h000000FF;
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      // write: setup then access
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_index == psrl_pkg::REG_HIT_LIMIT) limit_cfg = value[15:0];
      else window_cfg = value[7:0];
      // read back, same address, psel kept high
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if ((readback & mask) != (value & mask)) begin
         csr_error_count++;
         if (csr_error_count <= MAX_REPORTS)
            $display("%0t: register %0d readback expected %h, got %h",
                     $time, reg_index, value & mask, readback & mask);
      end
   endtask

   // Next random request: mostly repeating sources on a slow clock, some noise
   task automatic next_request(output request_type rq);
      int r;
      r = $urandom_range(99);
      if (r >= 70) begin
         if (r < 92) wall_clock = wall_clock + 32'd1;
         else if (r < 96) wall_clock = wall_clock + $urandom_range(300, 2);
         else if (r < 98) wall_clock = wall_clock - $urandom_range(5, 1);
         else wall_clock = $urandom;
      end
      if ($urandom_range(99) < 85) begin
         rq = source_pool[$urandom_range(POOL_SIZE - 1)];
         // bytes outside the key change freely
         if (rq.kind != psrl_pkg::KIND_IPV6) begin
            rq.upper[31:0] = $urandom;
            rq.lower = {$urandom, $urandom};
         end
         if (rq.kind == psrl_pkg::KIND_OTHER || rq.kind == KIND_UNUSED)
            rq.upper[63:32] = $urandom;
      end else begin
         rq.kind = 2'($urandom_range(3));
         rq.upper = {$urandom, $urandom};
         rq.lower = {$urandom, $urandom};
      end
      rq.now = wall_clock;
   endtask

   task automatic run_phase(input logic [31:0] limit, input logic [31:0] window,
                            input int send_pct, input int recv_pct, input bit with_hold);
      request_type rq;
      set_register(psrl_pkg::REG_HIT_LIMIT, limit);
      set_register(psrl_pkg::REG_WINDOW, window);
      // fresh pool: two no-address sources, ten IPv4, twelve IPv6
      for (int k = 0; k < POOL_SIZE; k++) begin
         if (k == 0) source_pool[k].kind = psrl_pkg::KIND_OTHER;
         else if (k == 1) source_pool[k].kind = KIND_UNUSED;
         else if (k < 12) source_pool[k].kind = psrl_pkg::KIND_IPV4;
         else source_pool[k].kind = psrl_pkg::KIND_IPV6;
         source_pool[k].upper = {$urandom, $urandom};
         source_pool[k].lower = {$urandom, $urandom};
         source_pool[k].now = '0;
      end
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      if (with_hold) hold_asks <= hold_asks + 1;
      repeat (PHASE_ITEMS) begin
         next_request(rq);
         send_request(rq, PREDICTED, 1'b0, psrl_pkg::OUT_RESTART);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker
   always @(posedge clock) begin
      verdict_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: expected no rsp word, got %h", $time, rsp_tdata);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== want.allowed ||
                rsp_tdata[psrl_pkg::SLOT_W:1] !== want.slot ||
                rsp_tdata[psrl_pkg::SLOT_W+3:psrl_pkg::SLOT_W+1] !== want.outcome) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           $time, want.allowed, want.slot, want.outcome, rsp_tdata[0],
                           rsp_tdata[psrl_pkg::SLOT_W:1],
                           rsp_tdata[psrl_pkg::SLOT_W+3:psrl_pkg::SLOT_W+1]);
            end
         end
      end
   end

   // Watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < psrl_pkg::TABLE_SLOTS; k++) begin
         shadow_upper[k] = '0;
         shadow_lower[k] = '0;
         shadow_length[k] = '0;
         shadow_start[k] = '0;
         shadow_hits[k] = '0;
      end
      limit_cfg = psrl_pkg::HIT_LIMIT_RESET;
      window_cfg = psrl_pkg::WINDOW_RESET;
      wall_clock = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table, reset registers: limit 100, window 1.
      // No-address requests share the empty slot 5381 mod 512 = 261.
      req_step(psrl_pkg::KIND_OTHER, '1, '1, 32'd0, TYPED, 1'b1, psrl_pkg::OUT_COUNTED);
      req_step(KIND_UNUSED, '1, '1, 32'd0, TYPED, 1'b1, psrl_pkg::OUT_COUNTED);
      req_step(psrl_pkg::KIND_OTHER, '0, '0, 32'hFFFFFFFF, TYPED, 1'b1,
               psrl_pkg::OUT_RESTART);
      // time wraps: 0 - 0xFFFFFFFF = 1, window over
      req_step(psrl_pkg::KIND_OTHER, '0, '0, 32'd0, TYPED, 1'b1, psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd10, TYPED, 1'b1,
               psrl_pkg::OUT_CLAIMED);
      // IPv4: low bytes ignored, same key
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER_ALT, '1, 32'd10, TYPED, 1'b1,
               psrl_pkg::OUT_COUNTED);
      req_step(psrl_pkg::KIND_IPV6, '1, '1, 32'd20, PREDICTED, 1'b0, psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_IPV6, '0, '0, 32'd20, PREDICTED, 1'b0, psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_IPV6, 64'h20010DB8_00000000, 64'h1, 32'd5, PREDICTED, 1'b0,
               psrl_pkg::OUT_RESTART);
      // clock moves back
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd9, TYPED, 1'b1,
               psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_IPV4, '1, '0, 32'd0, PREDICTED, 1'b0, psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_IPV4, '0, '1, 32'd0, PREDICTED, 1'b0, psrl_pkg::OUT_RESTART);
      // limit zero drops a counted hit
      csr_step(STEP_LIMIT, 32'd0);
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd9, TYPED, 1'b0,
               psrl_pkg::OUT_DROPPED);
      // window zero restarts every hit, restart still passes
      csr_step(STEP_WINDOW, 32'd0);
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd9, TYPED, 1'b1,
               psrl_pkg::OUT_RESTART);
      csr_step(STEP_LIMIT, 32'd2);
      csr_step(STEP_WINDOW, 32'd255);
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd100, TYPED, 1'b1,
               psrl_pkg::OUT_COUNTED);
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd100, TYPED, 1'b0,
               psrl_pkg::OUT_DROPPED);
      // drops keep counting; last second of the window, then just past it
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd263, TYPED, 1'b0,
               psrl_pkg::OUT_DROPPED);
      req_step(psrl_pkg::KIND_IPV4, HOST_UPPER, HOST_LOWER, 32'd264, TYPED, 1'b1,
               psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_OTHER, '0, '0, 32'd264, PREDICTED, 1'b0,
               psrl_pkg::OUT_RESTART);
      req_step(psrl_pkg::KIND_IPV6, '1, '1, 32'd300, PREDICTED, 1'b0, psrl_pkg::OUT_RESTART);

      foreach (directed_steps[i]) begin
         case (directed_steps[i].op)
            STEP_REQUEST: send_request(directed_steps[i].rq, directed_steps[i].typed,
                                       directed_steps[i].allowed, directed_steps[i].outcome);
            STEP_LIMIT:   set_register(psrl_pkg::REG_HIT_LIMIT, directed_steps[i].value);
            STEP_WINDOW:  set_register(psrl_pkg::REG_WINDOW, directed_steps[i].value);
            default:      set_register(psrl_pkg::REG_WINDOW, directed_steps[i].value);
         endcase
      end

      // Random phases: sender light and receiver heavy, then swapped, then none
      run_phase(32'd3, 32'd4, 6, 67, 1'b0);
      run_phase(32'd1, 32'd255, 67, 6, 1'b0);
      run_phase(32'd65535, 32'd1, 0, 0, 1'b1);

      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && csr_error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
